FILE: design/lfu_pkg.sv
package lfu_pkg;

  localparam int unsigned Entries  = 16;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned OccW     = $clog2(Entries + 1);
  localparam int unsigned CapW     = 5;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CntW     = 32;
  localparam int unsigned StampW   = 64;
  localparam logic [ValW-1:0] MissValue = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch request for the key compare
    logic scan;      // register the key compare and the victim / free-slot search
    logic do_get;    // touch hit slot, build get result
    logic do_upd;    // overwrite hit slot value, touch
    logic do_ins;    // evict if needed, insert new key
    logic do_none;   // result only, no state change
  } lfu_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic     hit;
    op_e      op;
    logic     cap_zero;
  } lfu_sts_t;

endpackage

FILE: design/lfu_ctrl.sv
module lfu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  input  lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   res_valid_q;
  logic   exec_go;

  // a new item may enter whenever the pipeline is idle
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  // the update waits while the previous result is still unclaimed
  assign exec_go     = (state_q == ST_EXEC) && (!res_valid_q || res_ready_i);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.scan = (state_q == ST_CMP);
    if (exec_go) begin
      if (sts_i.op == OP_GET) begin
        cmd_o.do_get = 1'b1;
      end else if (sts_i.cap_zero) begin
        cmd_o.do_none = 1'b1;
      end else if (sts_i.hit) begin
        cmd_o.do_upd = 1'b1;
      end else begin
        cmd_o.do_ins = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      if (exec_go) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (cmd_o.load) state_q <= ST_CMP;
        ST_CMP:  state_q <= ST_SCAN;
        ST_SCAN: state_q <= ST_EXEC;
        ST_EXEC: if (exec_go) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/lfu_dp.sv
module lfu_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]    cfg_data_i,
  input  logic                        op_i,
  input  logic [lfu_pkg::KeyW-1:0]    key_i,
  input  logic [lfu_pkg::ValW-1:0]    val_i,
  input  lfu_pkg::lfu_cmd_t           cmd_i,
  output lfu_pkg::lfu_sts_t           sts_o,
  output logic                        hit_o,
  output logic [lfu_pkg::ValW-1:0]    read_value_o,
  output logic [lfu_pkg::OccW-1:0]    occupancy_o
);
  import lfu_pkg::*;

  logic [CapW-1:0]   cap_q;
  logic [Entries-1:0] valid_q;
  logic [KeyW-1:0]   key_q   [Entries];
  logic [ValW-1:0]   val_q   [Entries];
  logic [CntW-1:0]   cnt_q   [Entries];
  logic [StampW-1:0] stamp_q [Entries];
  logic [StampW-1:0] clock_q;
  logic [OccW-1:0]   occ_q;

  op_e             op_q;
  logic [KeyW-1:0] rkey_q;
  logic [ValW-1:0] rval_q;
  logic            hit_q;
  logic [IdxW-1:0] hidx_q;
  logic            free_any_q;
  logic [IdxW-1:0] free_q;
  logic            vic_any_q;
  logic [IdxW-1:0] vic_q;
  logic            res_hit_q;
  logic [ValW-1:0] res_val_q;

  // effective capacity, clamped to table size
  logic [OccW-1:0] cap_eff;
  assign cap_eff = (cap_q > CapW'(Entries)) ? OccW'(Entries) : OccW'(cap_q);

  // parallel key compare
  logic [Entries-1:0] match;
  logic               hit_d;
  logic [IdxW-1:0]    hidx_d;
  always_comb begin
    hit_d  = 1'b0;
    hidx_d = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (key_q[i] == rkey_q);
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_d  = 1'b1;
        hidx_d = IdxW'(i);
      end
    end
  end

  // victim search as a pairwise tree of min (count, stamp), lower index wins ties
  logic              node_any   [1:2*Entries-1];
  logic [IdxW-1:0]   node_idx   [1:2*Entries-1];
  logic [CntW-1:0]   node_cnt   [1:2*Entries-1];
  logic [StampW-1:0] node_stamp [1:2*Entries-1];
  logic              take_hi;
  always_comb begin
    take_hi = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      node_any[Entries + i]   = valid_q[i];
      node_idx[Entries + i]   = IdxW'(i);
      node_cnt[Entries + i]   = cnt_q[i];
      node_stamp[Entries + i] = stamp_q[i];
    end
    for (int n = Entries - 1; n >= 1; n--) begin
      take_hi = node_any[2*n+1] && (!node_any[2*n] ||
                node_cnt[2*n+1] < node_cnt[2*n] ||
                (node_cnt[2*n+1] == node_cnt[2*n] &&
                 node_stamp[2*n+1] < node_stamp[2*n]));
      node_any[n]   = node_any[2*n] || node_any[2*n+1];
      node_idx[n]   = take_hi ? node_idx[2*n+1]   : node_idx[2*n];
      node_cnt[n]   = take_hi ? node_cnt[2*n+1]   : node_cnt[2*n];
      node_stamp[n] = take_hi ? node_stamp[2*n+1] : node_stamp[2*n];
    end
  end

  // free slot search: lowest invalid
  logic            free_any_d;
  logic [IdxW-1:0] free_d;
  logic            vic_any_d;
  logic [IdxW-1:0] vic_d;
  always_comb begin
    free_any_d = 1'b0;
    free_d     = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any_d = 1'b1;
        free_d     = IdxW'(i);
      end
    end
    vic_any_d = node_any[1];
    vic_d     = node_idx[1];
  end

  logic need_evict;
  assign need_evict = (occ_q >= cap_eff) && vic_any_q;

  logic [IdxW-1:0] ins_idx;
  logic            ins_ok;
  always_comb begin
    ins_idx = free_q;
    ins_ok  = free_any_q;
    if (need_evict) begin
      // after evicting, lowest invalid is min of victim and free slot
      ins_ok  = 1'b1;
      ins_idx = (!free_any_q || vic_q < free_q) ? vic_q : free_q;
    end
  end

  logic [Entries-1:0] valid_d;
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.do_ins && ins_ok) begin
      if (need_evict) valid_d[vic_q] = 1'b0;
      valid_d[ins_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapW'(Entries);
      valid_q <= '0;
      clock_q <= '0;
      occ_q   <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if ((cmd_i.do_get && hit_q) || cmd_i.do_upd || (cmd_i.do_ins && ins_ok)) begin
        clock_q <= clock_q + 1'b1;
      end
      valid_q <= valid_d;
      if (cmd_i.do_ins && ins_ok && !need_evict) occ_q <= occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      rkey_q <= key_i;
      rval_q <= val_i;
    end
    if (cmd_i.scan) begin
      hit_q      <= hit_d;
      hidx_q     <= hidx_d;
      free_any_q <= free_any_d;
      free_q     <= free_d;
      vic_any_q  <= vic_any_d;
      vic_q      <= vic_d;
    end
    if ((cmd_i.do_get && hit_q) || cmd_i.do_upd) begin
      if (cnt_q[hidx_q] != '1) cnt_q[hidx_q] <= cnt_q[hidx_q] + 1'b1;
      stamp_q[hidx_q] <= clock_q;
    end
    if (cmd_i.do_upd) val_q[hidx_q] <= rval_q;
    if (cmd_i.do_ins && ins_ok) begin
      key_q[ins_idx]   <= rkey_q;
      val_q[ins_idx]   <= rval_q;
      cnt_q[ins_idx]   <= CntW'(1);
      stamp_q[ins_idx] <= clock_q;
    end
    if (cmd_i.do_get) begin
      res_hit_q <= hit_q;
      res_val_q <= hit_q ? val_q[hidx_q] : MissValue;
    end else if (cmd_i.do_upd || cmd_i.do_ins || cmd_i.do_none) begin
      res_hit_q <= 1'b0;
      res_val_q <= MissValue;
    end
  end

  assign sts_o.hit      = hit_q;
  assign sts_o.op       = op_q;
  assign sts_o.cap_zero = (cap_eff == '0);
  assign hit_o          = res_hit_q;
  assign read_value_o   = res_val_q;
  assign occupancy_o    = occ_q;

endmodule

FILE: design/lfu_cache_table.sv
// channel   | dir | tdata fields (low bit up)               | tuser
// s_axis    | in  | lookup_key[31:0], write_value[63:32]     | opcode
// m_axis    | out | read_value[31:0]                         | hit
// cfg       | in  | capacity_in_use[4:0] on cfg_wdata_i      | -
//
// one item steps through accept, key compare together with the victim / free-slot
// tree search (registered at once), a hold cycle, then update;
// the update writes the table and the output register in the same cycle
// a stalled m_axis keeps the result in the output register; the next beat is
// still accepted and waits in the update stage until the result is taken
// after reset the table is empty and capacity is 16
module lfu_cache_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // lookup_key, write_value
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_value
  output logic        m_axis_tuser    // hit
);
  import lfu_pkg::*;

  lfu_cmd_t        cmd;
  lfu_sts_t        sts;
  logic [OccW-1:0] occ;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_wdata_i),
    .op_i         (s_axis_tuser),
    .key_i        (s_axis_tdata[31:0]),
    .val_i        (s_axis_tdata[63:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .hit_o        (m_axis_tuser),
    .read_value_o (m_axis_tdata),
    .occupancy_o  (occ)
  );

`ifndef SYNTHESIS
  // occupancy never exceeds the table
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OccW'(Entries)) else $error("occupancy overflow");
  // at most one action command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.do_get, cmd.do_upd, cmd.do_ins, cmd.do_none}))
    else $error("multiple actions");
  // a put never reports a hit
  a_put_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.do_upd || cmd.do_ins || cmd.do_none) |=> !m_axis_tuser)
    else $error("put reported hit");
  // an action is followed by a pending result
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.do_get || cmd.do_upd || cmd.do_ins || cmd.do_none) |=> m_axis_tvalid)
    else $error("result lost");
`endif

endmodule
